FILE: rtl/core/hashed_record_lookup_insert_core_macros.svh
// Assertion macros for the hashed record lookup/insert core.
// Included by the top level; no other dependencies.
`ifndef HASHED_RECORD_LOOKUP_INSERT_CORE_MACROS_SVH
`define HASHED_RECORD_LOOKUP_INSERT_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define HRLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrli assertion failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define HRLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrli assertion failed");
`else
`define HRLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HRLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/hrli_pkg.sv
// Shared types and constants for the hashed record lookup/insert core.
// No dependencies; compiled first.
`default_nettype none
package hrli_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [31:0] FNV_OFFSET = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int HASH_W  = 32;
    localparam int TALLY_W = 32;

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_INSERT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic {
        BK_IDLE,
        BK_SEARCH
    } t_back_state;

    // Command handed from the front end to the back end.
    typedef struct packed {
        logic              is_clear;
        logic [HASH_W-1:0] key;
    } t_cmd;

    // One finished lookup result.
    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] entry_index;
        logic [HASH_W-1:0]  key_hash;
        logic [TALLY_W-1:0] hit_count;
        logic [TALLY_W-1:0] miss_count;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/core/hrli_if.sv
// Valid/ready channel interfaces for the record byte input and the lookup result.
// Depends on hrli_pkg for field widths.
`default_nettype none
interface hrli_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;
    logic       last;

    modport source(output valid, output op, output data_byte, output last, input ready);
    modport sink(input valid, input op, input data_byte, input last, output ready);
endinterface

interface hrli_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [hrli_pkg::INDEX_W-1:0]     entry_index;
    logic [hrli_pkg::HASH_W-1:0]      key_hash;
    logic [hrli_pkg::TALLY_W-1:0]     hit_count;
    logic [hrli_pkg::TALLY_W-1:0]     miss_count;
    logic [hrli_pkg::COUNT_W-1:0]     entry_count;

    modport source(output valid, output status, output entry_index, output key_hash,
                   output hit_count, output miss_count, output entry_count, input ready);
    modport sink(input valid, input status, input entry_index, input key_hash,
                 input hit_count, input miss_count, input entry_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hrli_front.sv
// Front end: folds record bytes into the running FNV-1a hash and issues commands.
// Depends on hrli_pkg and hrli_in_if.
`default_nettype none
module hrli_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    hrli_in_if.sink           i_in,
    input  wire logic         i_q_full,
    output hrli_pkg::t_cmd    o_cmd,
    output logic              o_push
);

    logic [hrli_pkg::HASH_W-1:0] r_hash;
    logic [hrli_pkg::HASH_W-1:0] n_hash;
    logic [hrli_pkg::HASH_W-1:0] w_prod;
    logic                        w_accept;

    assign i_in.ready = ~i_q_full;
    assign w_accept   = i_in.valid & i_in.ready;

    // One multiply per byte; the product is registered either here or in the queue.
    assign w_prod = (r_hash ^ {24'd0, i_in.data_byte}) * hrli_pkg::FNV_PRIME;

    always_comb begin
        n_hash         = r_hash;
        o_push         = 1'b0;
        o_cmd.is_clear = i_in.op;
        o_cmd.key      = w_prod;
        if (w_accept) begin
            if (i_in.op) begin
                n_hash = hrli_pkg::FNV_OFFSET;
                o_push = 1'b1;
            end else if (i_in.last) begin
                n_hash = hrli_pkg::FNV_OFFSET;
                o_push = 1'b1;
            end else begin
                n_hash = w_prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= hrli_pkg::FNV_OFFSET;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/hrli_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on hrli_pkg.
`default_nettype none
module hrli_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hrli_pkg::t_cmd i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output hrli_pkg::t_cmd      o_cmd,
    input  wire logic           i_pop
);

    hrli_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_cmd     = r_slot[r_rd_ptr];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_do_push;
        n_rd_ptr = r_rd_ptr ^ w_do_pop;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/hrli_back.sv
// Back end: key table memory, sequential search, insert, counters and result register.
// Depends on hrli_pkg.
`default_nettype none
module hrli_back #(
    parameter int TABLE_DEPTH = hrli_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire hrli_pkg::t_cmd i_cmd,
    output logic                o_cmd_ready,
    output logic                o_res_valid,
    output hrli_pkg::t_result   o_res,
    input  wire logic           i_res_ready
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [hrli_pkg::HASH_W-1:0]  r_mem [TABLE_DEPTH];
    logic [hrli_pkg::HASH_W-1:0]  r_rd_data;
    logic [hrli_pkg::HASH_W-1:0]  r_key;

    hrli_pkg::t_back_state        r_state;
    hrli_pkg::t_back_state        n_state;
    logic [CNT_W-1:0]             r_idx;
    logic [CNT_W-1:0]             n_idx;
    logic                         r_pend;
    logic                         n_pend;
    logic [IDX_W-1:0]             r_pend_idx;
    logic [IDX_W-1:0]             n_pend_idx;
    logic [CNT_W-1:0]             r_fill;
    logic [CNT_W-1:0]             n_fill;
    logic [hrli_pkg::TALLY_W-1:0] r_hits;
    logic [hrli_pkg::TALLY_W-1:0] n_hits;
    logic [hrli_pkg::TALLY_W-1:0] r_misses;
    logic [hrli_pkg::TALLY_W-1:0] n_misses;
    logic                         r_out_valid;
    logic                         n_out_valid;
    hrli_pkg::t_result            r_out;

    logic                         w_match;
    logic                         w_scanned;
    logic                         w_full;
    logic                         w_out_free;
    logic                         w_finish;
    logic                         w_rd_en;
    logic                         w_wr_en;
    logic                         w_load;
    logic [IDX_W-1:0]             w_idx;
    logic [CNT_W-1:0]             w_cnt;
    logic [IDX_W+5:0]             w_idx_ext;
    logic [CNT_W+6:0]             w_cnt_ext;
    hrli_pkg::t_result            w_res;

    assign w_match    = r_pend && (r_rd_data == r_key);
    assign w_scanned  = (r_idx == r_fill);
    assign w_full     = (r_fill == CNT_W'(TABLE_DEPTH));
    assign w_out_free = ~r_out_valid | i_res_ready;
    assign w_finish   = (r_state == hrli_pkg::BK_SEARCH) && (w_match || w_scanned) && w_out_free;
    assign w_rd_en    = (r_state == hrli_pkg::BK_SEARCH) && !w_match && !w_scanned;
    assign w_wr_en    = w_finish && !w_match && !w_full;
    assign w_load     = (r_state == hrli_pkg::BK_IDLE) && i_cmd_valid && !i_cmd.is_clear;

    assign o_cmd_ready = (r_state == hrli_pkg::BK_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Result fields; index and count are masked to the result widths.
    always_comb begin
        if (w_match) begin
            w_res.status = hrli_pkg::ST_HIT;
            w_idx        = r_pend_idx;
            w_cnt        = r_fill;
        end else if (w_full) begin
            w_res.status = hrli_pkg::ST_FULL;
            w_idx        = '0;
            w_cnt        = r_fill;
        end else begin
            w_res.status = hrli_pkg::ST_INSERT;
            w_idx        = r_fill[IDX_W-1:0];
            w_cnt        = r_fill + CNT_W'(1);
        end
        w_idx_ext         = {6'd0, w_idx};
        w_cnt_ext         = {7'd0, w_cnt};
        w_res.entry_index = w_idx_ext[hrli_pkg::INDEX_W-1:0];
        w_res.entry_count = w_cnt_ext[hrli_pkg::COUNT_W-1:0];
        w_res.key_hash    = r_key;
        w_res.hit_count   = w_match ? r_hits + 32'd1 : r_hits;
        w_res.miss_count  = w_match ? r_misses : r_misses + 32'd1;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_fill      = r_fill;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_out_valid = r_out_valid & ~i_res_ready;
        unique case (r_state)
            hrli_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_clear) begin
                        n_fill   = '0;
                        n_hits   = '0;
                        n_misses = '0;
                    end else begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = hrli_pkg::BK_SEARCH;
                    end
                end
            end
            hrli_pkg::BK_SEARCH: begin
                if (w_rd_en) begin
                    n_idx      = r_idx + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[IDX_W-1:0];
                end
                if (w_finish) begin
                    n_state     = hrli_pkg::BK_IDLE;
                    n_pend      = 1'b0;
                    n_out_valid = 1'b1;
                    n_hits      = w_res.hit_count;
                    n_misses    = w_res.miss_count;
                    if (w_wr_en) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = hrli_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrli_pkg::BK_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_idx  <= '0;
            r_fill      <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_pend_idx  <= n_pend_idx;
            r_fill      <= n_fill;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key <= i_cmd.key;
        end
        if (w_finish) begin
            r_out <= w_res;
        end
    end

    // Key table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_fill[IDX_W-1:0]] <= r_key;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/hashed_record_lookup_insert_core.sv
// Top level of the hashed record lookup/insert core.
// Depends on hrli_pkg, hrli_if, hrli_front, hrli_cmd_fifo, hrli_back and the macro header.
//
//  Channel  | Direction | Payload                                               | Transfer
//  ---------+-----------+-------------------------------------------------------+---------------
//  i_in     | in        | op, data_byte, last                                   | valid & ready
//  o_out    | out       | status, entry_index, key_hash, hit_count, miss_count, | valid & ready
//           |           | entry_count                                           |
//
// A byte is taken in any cycle in which the two-entry command queue has a free slot; a
// last byte or a clear posts a command there, other bytes only update the running hash.
// A lookup reads the filled entries one by one through the single read port of the key
// table, ending at the first hit or after the last filled entry; a clear needs no search.
// Reset is synchronous and active low and zeroes the fill count and counters; the key
// table needs no clearing pass. A stalled result waits in the output register.
`default_nettype none
`include "hashed_record_lookup_insert_core_macros.svh"
module hashed_record_lookup_insert_core #(
    parameter int TABLE_DEPTH = hrli_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hrli_in_if.sink     i_in,
    hrli_out_if.source  o_out
);

    // Command path from the front end into the queue and from the queue to the back end.
    hrli_pkg::t_cmd    w_push_cmd;
    logic              w_push;
    logic              w_q_full;
    logic              w_q_valid;
    hrli_pkg::t_cmd    w_q_cmd;
    logic              w_q_pop;
    logic              w_res_valid;
    hrli_pkg::t_result w_res;

    // The front end hashes bytes as they arrive and posts a command at record end.
    hrli_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_cmd    (w_push_cmd),
        .o_push   (w_push)
    );

    // The queue lets the next record be hashed while a search is still running.
    hrli_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    // The back end owns the key table and all counters.
    hrli_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_ready (w_q_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (o_out.ready)
    );

    assign o_out.valid       = w_res_valid;
    assign o_out.status      = w_res.status;
    assign o_out.entry_index = w_res.entry_index;
    assign o_out.key_hash    = w_res.key_hash;
    assign o_out.hit_count   = w_res.hit_count;
    assign o_out.miss_count  = w_res.miss_count;
    assign o_out.entry_count = w_res.entry_count;

    // A full-table result always reports entry zero.
    `HRLI_ASSERT_IMPL(a_full_index_zero, i_clk, i_rst_n, o_out.valid && (o_out.status == hrli_pkg::ST_FULL), o_out.entry_index == '0)
    // A fresh insert lands just below the new fill count.
    `HRLI_ASSERT_IMPL(a_insert_count, i_clk, i_rst_n, o_out.valid && (o_out.status == hrli_pkg::ST_INSERT), o_out.entry_count[5:0] == 6'(o_out.entry_index + 6'd1))
    // A posted command is waiting in the queue on the following cycle.
    `HRLI_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push, w_q_valid)

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for hashed_record_lookup_insert_core.
// Depends on hrli_pkg and the hrli_in_if / hrli_out_if channel interfaces.
// Record bytes go in through a queue-fed driver, and a monitor checks each lookup result.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = hrli_pkg::TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1730;
    localparam int POOL_N       = 48;
    localparam int MAX_REC      = 20;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_ITEMS  = 120;

    // Input operation codes.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // One input transfer as queued by the stimulus. The drain flag makes the driver
    // hold it back until every lookup result already owed has come out.
    typedef struct {
        logic       op;
        logic [7:0] data;
        logic       last;
        bit         drain_first;
    } t_rec_byte;

    logic i_clk;
    logic i_rst_n;

    hrli_in_if  byte_if();
    hrli_out_if lookup_if();

    hashed_record_lookup_insert_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (lookup_if)
    );

    // Bytes waiting to be driven, and lookup results owed by the block, oldest first.
    t_rec_byte         byte_stream[$];
    hrli_pkg::t_result lookup_results_due[$];

    // Shadow copy of the block's state, advanced on every accepted input transfer.
    logic [31:0] run_hash;
    logic [31:0] key_table[DEPTH];
    int          keys_filled;
    logic [31:0] hit_tally;
    logic [31:0] miss_tally;

    int n_errors;
    int n_sent;
    int phase;
    int idle_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_failure(input string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // Folds one accepted input into the shadow state. A last byte finishes the
    // FNV-1a hash, scans the filled entries lowest index first, and queues the
    // result the block owes for that record.
    task automatic fold_and_lookup(input logic op, input logic [7:0] data, input logic last);
        hrli_pkg::t_result res;
        logic [31:0]       key;
        int                found_at;
        if (op == OP_CLEAR) begin
            keys_filled = 0;
            hit_tally   = '0;
            miss_tally  = '0;
            run_hash    = hrli_pkg::FNV_OFFSET;
        end else begin
            run_hash = (run_hash ^ {24'd0, data}) * hrli_pkg::FNV_PRIME;
            if (last) begin
                key      = run_hash;
                run_hash = hrli_pkg::FNV_OFFSET;
                found_at = -1;
                for (int i = 0; i < keys_filled; i++) begin
                    if (found_at < 0 && key_table[i] == key) begin
                        found_at = i;
                    end
                end
                if (found_at >= 0) begin
                    hit_tally       = hit_tally + 32'd1;
                    res.status      = hrli_pkg::ST_HIT;
                    res.entry_index = hrli_pkg::INDEX_W'(found_at);
                end else begin
                    miss_tally = miss_tally + 32'd1;
                    if (keys_filled >= DEPTH) begin
                        res.status      = hrli_pkg::ST_FULL;
                        res.entry_index = '0;
                    end else begin
                        key_table[keys_filled] = key;
                        res.status      = hrli_pkg::ST_INSERT;
                        res.entry_index = hrli_pkg::INDEX_W'(keys_filled);
                        keys_filled++;
                    end
                end
                res.key_hash    = key;
                res.hit_count   = hit_tally;
                res.miss_count  = miss_tally;
                res.entry_count = hrli_pkg::COUNT_W'(keys_filled);
                lookup_results_due.push_back(res);
            end
        end
    endtask

    task automatic push_item(input logic op, input logic [7:0] data, input logic last,
                             input bit drain_first);
        t_rec_byte item;
        item.op          = op;
        item.data        = data;
        item.last        = last;
        item.drain_first = drain_first;
        byte_stream.push_back(item);
    endtask

    // Driver. A transfer happens at an edge where valid and ready were both high
    // just before it; the accepted item is predicted from the values still on the
    // channel, then the next one is offered if the slot is free.
    always @(posedge i_clk) begin
        int        idle_pct;
        t_rec_byte item;
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                fold_and_lookup(byte_if.op, byte_if.data_byte, byte_if.last);
                n_sent++;
            end
            // The idling pattern moves through its phases in chunks of transfers, so
            // every phase is visited several times over the run.
            phase <= (n_sent / PHASE_ITEMS) % 4;
            case (phase)
                1: idle_pct = 66;
                3: idle_pct = 14;
                default: idle_pct = 0;
            endcase
            if (!byte_if.valid || byte_if.ready) begin
                if (byte_stream.size() != 0 && $urandom_range(99) >= idle_pct &&
                    !(byte_stream[0].drain_first && lookup_results_due.size() != 0)) begin
                    item = byte_stream.pop_front();
                    byte_if.valid     <= 1'b1;
                    byte_if.op        <= item.op;
                    byte_if.data_byte <= item.data;
                    byte_if.last      <= item.last;
                end else begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every result transfer is matched against the oldest owed result,
    // field by field; anything unexpected counts as a failure and the run goes on.
    always @(posedge i_clk) begin
        int                stall_pct;
        hrli_pkg::t_result want;
        if (!i_rst_n) begin
            lookup_if.ready <= 1'b0;
        end else begin
            if (lookup_if.valid && lookup_if.ready) begin
                if (lookup_results_due.size() == 0) begin
                    report_failure($sformatf("result with none owed: hash %08h",
                                             lookup_if.key_hash));
                end else begin
                    want = lookup_results_due.pop_front();
                    if (lookup_if.status !== want.status ||
                        lookup_if.entry_index !== want.entry_index ||
                        lookup_if.key_hash !== want.key_hash ||
                        lookup_if.hit_count !== want.hit_count ||
                        lookup_if.miss_count !== want.miss_count ||
                        lookup_if.entry_count !== want.entry_count) begin
                        report_failure($sformatf(
                            {"want st=%0d idx=%0d hash=%08h hit=%0d miss=%0d cnt=%0d, ",
                             "got st=%0d idx=%0d hash=%08h hit=%0d miss=%0d cnt=%0d"},
                            want.status, want.entry_index, want.key_hash, want.hit_count,
                            want.miss_count, want.entry_count,
                            lookup_if.status, lookup_if.entry_index, lookup_if.key_hash,
                            lookup_if.hit_count, lookup_if.miss_count,
                            lookup_if.entry_count));
                    end
                end
            end
            case (phase)
                2: stall_pct = 66;
                3: stall_pct = 14;
                default: stall_pct = 0;
            endcase
            lookup_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a long stretch with no transfer on either channel means a hang.
    // A full-table lookup ends well within the limit.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((byte_if.valid && byte_if.ready) || (lookup_if.valid && lookup_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] pool_bytes[POOL_N][MAX_REC];
        int         pool_len[POOL_N];
        int         pool_fill;
        int         n_queued;
        int         since_clear;
        int         slot;
        int         r;
        int         cut;
        bit         first_clear;

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        byte_if.valid      = 1'b0;
        byte_if.op         = OP_BYTE;
        byte_if.data_byte  = 8'd0;
        byte_if.last       = 1'b0;
        lookup_if.ready    = 1'b0;
        n_errors           = 0;
        n_sent             = 0;
        phase              = 0;
        idle_cycles        = 0;
        keys_filled        = 0;
        hit_tally          = '0;
        miss_tally         = '0;
        run_hash           = hrli_pkg::FNV_OFFSET;

        // Directed part: single-byte records at both byte extremes, a repeat that
        // must hit, a multi-byte record, a clear that drops a record in progress
        // (with its data and last fields set, which must be ignored), back-to-back
        // clears, and a pause until the block has gone quiet.
        push_item(OP_BYTE, 8'h00, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'hff, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'h00, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'ha5, 1'b0, 1'b0);
        push_item(OP_BYTE, 8'h5a, 1'b0, 1'b0);
        push_item(OP_BYTE, 8'hff, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'hff, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'h3c, 1'b0, 1'b0);
        push_item(OP_CLEAR, 8'hff, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'h00, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'ha5, 1'b0, 1'b0);
        push_item(OP_BYTE, 8'h5a, 1'b0, 1'b0);
        push_item(OP_BYTE, 8'hff, 1'b1, 1'b0);
        push_item(OP_CLEAR, 8'h00, 1'b0, 1'b0);
        push_item(OP_BYTE, 8'h80, 1'b1, 1'b1);
        push_item(OP_CLEAR, 8'h55, 1'b0, 1'b0);
        push_item(OP_CLEAR, 8'haa, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'h01, 1'b0, 1'b0);
        push_item(OP_BYTE, 8'hfe, 1'b1, 1'b0);
        push_item(OP_BYTE, 8'h01, 1'b0, 1'b0);
        push_item(OP_BYTE, 8'hfe, 1'b1, 1'b0);

        // Random part: mostly complete records, some replayed from a pool so that
        // lookups hit, the rest new so that the table fills up and reports full.
        // Clears are held off long enough for the table to fill in between, and
        // half of them cut a record short.
        n_queued    = byte_stream.size();
        pool_fill   = 0;
        since_clear = 0;
        first_clear = 1'b1;
        push_item(OP_BYTE, 8'($urandom), 1'b1, 1'b1);
        n_queued++;
        while (n_queued < RANDOM_ITEMS + 21) begin
            if (since_clear > 130 && $urandom_range(39) == 0) begin
                if ($urandom_range(1) == 1) begin
                    cut = $urandom_range(5, 1);
                    for (int i = 0; i < cut; i++) begin
                        push_item(OP_BYTE, 8'($urandom), 1'b0, 1'b0);
                    end
                end
                push_item(OP_CLEAR, 8'($urandom), 1'($urandom), first_clear);
                first_clear = 1'b0;
                since_clear = 0;
            end else begin
                if (pool_fill > 0 && $urandom_range(99) < 45) begin
                    slot = $urandom_range(pool_fill - 1);
                end else begin
                    if (pool_fill < POOL_N) begin
                        slot = pool_fill;
                        pool_fill++;
                    end else begin
                        slot = $urandom_range(POOL_N - 1);
                    end
                    r = $urandom_range(99);
                    if (r < 70) begin
                        pool_len[slot] = $urandom_range(3, 1);
                    end else if (r < 95) begin
                        pool_len[slot] = $urandom_range(8, 4);
                    end else begin
                        pool_len[slot] = $urandom_range(MAX_REC, 9);
                    end
                    for (int i = 0; i < pool_len[slot]; i++) begin
                        pool_bytes[slot][i] = 8'($urandom);
                    end
                end
                for (int i = 0; i < pool_len[slot]; i++) begin
                    push_item(OP_BYTE, pool_bytes[slot][i], i == pool_len[slot] - 1, 1'b0);
                end
                since_clear++;
            end
            n_queued = byte_stream.size();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait for the stimulus to be taken, then for every owed result,
        // then a tail long enough for a full-table search to surface anything stray.
        while (byte_stream.size() != 0 || byte_if.valid) begin
            @(posedge i_clk);
        end
        while (lookup_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DEPTH + 8) @(posedge i_clk);
        if (lookup_results_due.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", lookup_results_due.size()));
        end
        if (n_errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: hashed_record_lookup_insert_core.f
+incdir+rtl/core
rtl/core/hrli_pkg.sv
rtl/core/hrli_if.sv
rtl/core/hrli_front.sv
rtl/core/hrli_cmd_fifo.sv
rtl/core/hrli_back.sv
rtl/core/hashed_record_lookup_insert_core.sv
tb/testbench.sv
